// ===== rtl/core/eps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eps_pkg
// Shared types and constants of the enable power sequencer.
// ----------------------------------------------------------------------------
package eps_pkg;

  localparam int unsigned CntW = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [2:0] {
    PH_STOPPED = 3'd0,
    PH_DEB1    = 3'd1,
    PH_DEB2    = 3'd2,
    PH_DEB3    = 3'd3,
    PH_SETTLE  = 3'd4,
    PH_STARTED = 3'd5,
    PH_KEEP    = 3'd6
  } phase_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SETTLE_TICKS = 2'd0,
    REG_KEEP_TICKS   = 2'd1,
    REG_FORCE_ENABLE = 2'd2
  } cfg_reg_t;

  localparam cnt_t SettleReset = 16'd10;
  localparam cnt_t KeepReset   = 16'd10;

  typedef struct packed {
    cnt_t settle_ticks;
    cnt_t keep_ticks;
    logic force_enable;
  } cfg_t;

endpackage

// ===== rtl/core/eps_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eps_seq
// Next-state logic of the sequencer: countdown step and phase transition
// for one poll.
// ----------------------------------------------------------------------------
module eps_seq import eps_pkg::*; (
  input  logic [2:0] phase_i,
  input  cnt_t       cnt_i,
  input  logic       en_i,
  input  logic       tick_i,
  input  cfg_t       cfg_i,
  output logic [2:0] phase_o,
  output cnt_t       cnt_o
);

  cnt_t cnt_dec;

  assign cnt_dec = (tick_i && (cnt_i != '0)) ? cnt_i - cnt_t'(1) : cnt_i;

  always_comb begin
    phase_o = phase_i;
    cnt_o   = cnt_dec;
    unique case (phase_i)
      PH_STOPPED, PH_DEB1, PH_DEB2: begin
        phase_o = en_i ? phase_i + 3'd1 : PH_STOPPED;
      end
      PH_DEB3: begin
        if (!en_i) begin
          phase_o = PH_STOPPED;
        end else begin
          phase_o = PH_SETTLE;
          cnt_o   = cfg_i.settle_ticks;
        end
      end
      PH_SETTLE: begin
        if (en_i) begin
          if (cnt_dec == '0) phase_o = PH_STARTED;
        end else begin
          phase_o = PH_KEEP;
          cnt_o   = cfg_i.keep_ticks;
        end
      end
      PH_STARTED: begin
        if (!en_i) begin
          phase_o = PH_KEEP;
          cnt_o   = cfg_i.keep_ticks;
        end
      end
      PH_KEEP: begin
        if (en_i) begin
          phase_o = PH_STARTED;
        end else if (cnt_dec == '0) begin
          phase_o = PH_STOPPED;
        end
      end
      default: begin
        phase_o = phase_i;
      end
    endcase
  end

endmodule

// ===== rtl/core/enable_power_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enable_power_sequencer
// Debounces an enable input, starts PWM, asserts enable-out after a settle
// time and keeps PWM running for a hold time after enable falls.
// ----------------------------------------------------------------------------
// One poll transaction is accepted per clock while the output register is
// not stalled: the poll is captured in an input register, the sequencer
// steps in short logic (a 16-bit decrement and the phase decode), and the
// result is held in an output register. Both stages stall only while the
// output register is full and not taken. Configuration is written through
// the cfg_ channel, which is always ready.
module enable_power_sequencer import eps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_enable_level,
  input  logic               in_tick,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_enable_out,
  output logic               out_pwm_on,
  output logic               out_controls_on,
  output logic [2:0]         out_phase,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CntW-1:0]    cfg_data
);

  cfg_t       cfg_r;
  logic       s1_valid_r;
  logic       s1_en_r;
  logic       s1_tick_r;
  logic [2:0] phase_r;
  cnt_t       cnt_r;
  logic [2:0] phase_nxt;
  cnt_t       cnt_nxt;
  logic       advance;
  logic       step;
  logic       en;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign step      = s1_valid_r && advance;
  assign en        = s1_en_r || cfg_r.force_enable;

  eps_seq u_seq (
    .phase_i (phase_r),
    .cnt_i   (cnt_r),
    .en_i    (en),
    .tick_i  (s1_tick_r),
    .cfg_i   (cfg_r),
    .phase_o (phase_nxt),
    .cnt_o   (cnt_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ticks <= SettleReset;
      cfg_r.keep_ticks   <= KeepReset;
      cfg_r.force_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SETTLE_TICKS: cfg_r.settle_ticks <= cfg_data;
        REG_KEEP_TICKS:   cfg_r.keep_ticks   <= cfg_data;
        REG_FORCE_ENABLE: cfg_r.force_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid  <= 1'b0;
      phase_r    <= PH_STOPPED;
      cnt_r      <= '0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (advance) out_valid <= s1_valid_r;
      if (step) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_en_r   <= in_enable_level;
      s1_tick_r <= in_tick;
    end
    if (step) begin
      out_enable_out  <= (phase_nxt == PH_STARTED);
      out_controls_on <= (phase_nxt == PH_STARTED);
      out_pwm_on      <= (phase_nxt == PH_SETTLE) || (phase_nxt == PH_STARTED) ||
                         (phase_nxt == PH_KEEP);
      out_phase       <= phase_nxt;
    end
  end

  // keep expiring with enable low stops the sequencer
  a_keep_expire : assert property (@(posedge clk) disable iff (!rst_n)
    step && (phase_r == PH_KEEP) && !en && (cnt_nxt == '0) |=> phase_r == PH_STOPPED)
    else $error("keep expiry did not stop");

  // countdown only rises on a load from settle or keep
  a_cnt_no_rise : assert property (@(posedge clk) disable iff (!rst_n)
    step && (phase_r != PH_DEB3) && (phase_r != PH_SETTLE) && (phase_r != PH_STARTED)
    |=> cnt_r <= $past(cnt_r))
    else $error("countdown rose without a load");

  // sequencer state moves only with a stepped poll
  a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(cnt_r))
    else $error("state changed without a poll");

  // result phase agrees with the registered state
  a_out_phase : assert property (@(posedge clk) disable iff (!rst_n)
    $past(step) |-> (out_phase == phase_r) && out_valid)
    else $error("result phase mismatch");

endmodule
